// ===== sv/stepper_ramp_profile_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Stepper ramp profile controller assertion macros
// Concurrent assertion wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef STEPPER_RAMP_PROFILE_CONTROLLER_MACROS_SVH
`define STEPPER_RAMP_PROFILE_CONTROLLER_MACROS_SVH

// Condition holds at every edge out of reset.
`define SRPC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define SRPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/srpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpc_pkg
// Shared types and constants of the stepper ramp profile controller.
// ----------------------------------------------------------------------------
package srpc_pkg;

    localparam int LEVELS_DEF = 14;

    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int LVL_W   = 4;
    localparam int TBL_W   = 16;
    localparam int SUM_W   = 20;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 48;
    localparam int ADDR_W  = 3;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_DIR     = 3'd1;
    localparam logic [OP_W-1:0] OP_TARGET  = 3'd2;
    localparam logic [OP_W-1:0] OP_BUDGET  = 3'd3;
    localparam logic [OP_W-1:0] OP_ENABLE  = 3'd4;
    localparam logic [OP_W-1:0] OP_DISABLE = 3'd5;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd6;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd7;

    localparam logic [1:0] MODE_STEADY = 2'd0;
    localparam logic [1:0] MODE_ACCEL  = 2'd1;
    localparam logic [1:0] MODE_DECEL  = 2'd2;
    localparam logic [1:0] MODE_STOP   = 2'd3;

    localparam logic REG_STOP_OFFSET = 1'b0;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EXEC = 9'b000000010,
        S_TICK = 9'b000000100,
        S_TBUD = 9'b000001000,
        S_DIV  = 9'b000010000,
        S_SUM  = 9'b000100000,
        S_BUD  = 9'b001000000,
        S_PRD  = 9'b010000000,
        S_LOAD = 9'b100000000
    } t_state;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic [VAL_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== sv/stepper_ramp_profile_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_profile_controller
// Trapezoidal speed ramp for one stepper motor, level table in a sync RAM.
// ----------------------------------------------------------------------------
//  channel    dir  transaction
//  s_axis     in   tuser = operation, tdata = value/index/period/dwell
//  m_axis     out  tdata = period/compare/level/mode/flags, one per input
//  apb        in   stop_offset at byte address 0
//
//  Tick while running: IDLE (table read), TICK, TBUD, PRD, LOAD; others EXEC, PRD, LOAD.
//  Set budget: EXEC, DIV (divide), SUM (dwell walk up to target level), BUD, PRD, LOAD.
//  Path length is set by the table RAM read and the dwell walk.
//  One item in flight; a pending result stalls only the next item's load.
//  Synchronous active-low reset; the level table is not cleared.
// ----------------------------------------------------------------------------
`include "stepper_ramp_profile_controller_macros.svh"

module stepper_ramp_profile_controller
    import srpc_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] value, [35:32] level_index, [51:36] level_period, [67:52] level_dwell
    input  logic [IN_W-1:0]   s_axis_tdata,
    // [2:0] operation
    input  logic [OP_W-1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [15:0] step_period, [30:16] step_compare, [34:31] speed_level,
    // [36:35] ramp_mode, [37] is_running, [38] budget_mode,
    // [39] driver_enable, [40] turn_dir
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int              AW      = $clog2(LEVELS);
    localparam logic [LVL_W:0]  LVL_CNT = (LVL_W + 1)'(LEVELS);
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS - 1);

    t_state r_state, n_state;

    logic [OP_W-1:0]  r_op;
    logic [VAL_W-1:0] r_val;
    logic [LVL_W-1:0] r_idx;
    logic [TBL_W-1:0] r_wper;
    logic [TBL_W-1:0] r_wdw;

    logic [LVL_W-1:0] r_level, n_level;
    logic [LVL_W-1:0] r_target, n_target;
    logic [1:0]       r_mode, n_mode;
    logic             r_run, n_run;
    logic             r_bf, n_bf;
    logic             r_dir, n_dir;
    logic [TBL_W-1:0] r_dc, n_dc;
    logic [TBL_W-1:0] r_oc, n_oc;
    logic [VAL_W-1:0] r_pc, n_pc;
    logic [VAL_W-1:0] r_budget, n_budget;
    logic [VAL_W-1:0] r_decel, n_decel;
    logic [TBL_W-1:0] r_stop_offset;

    logic [LVL_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic             r_acc_v, n_acc_v;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;
    logic             out_load;

    logic [2*TBL_W-1:0] r_mem [LEVELS];
    logic [2*TBL_W-1:0] r_rd_data;
    logic               mem_we;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic s_acc;
    logic cfg_wr;

    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && (paddr[2] == REG_STOP_OFFSET);
    assign prdata        = (paddr[2] == REG_STOP_OFFSET) ? {16'd0, r_stop_offset} : 32'd0;

    srpc_div3 u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        logic [TBL_W-1:0] dwell;
        logic [TBL_W-1:0] dc1;
        logic [TBL_W-1:0] dc_after;
        logic             hit;
        logic [LVL_W:0]   lvl_up;
        logic [LVL_W-1:0] lvl_dn;
        logic [TBL_W-1:0] oc1;
        logic [VAL_W-1:0] pc1;
        logic             issue;
        logic [TBL_W-1:0] per;
        n_state          = r_state;
        n_level          = r_level;
        n_target         = r_target;
        n_mode           = r_mode;
        n_run            = r_run;
        n_bf             = r_bf;
        n_dir            = r_dir;
        n_dc             = r_dc;
        n_oc             = r_oc;
        n_pc             = r_pc;
        n_budget         = r_budget;
        n_decel          = r_decel;
        n_cnt            = r_cnt;
        n_sum            = r_sum;
        n_acc_v          = r_acc_v;
        mem_we           = 1'b0;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = r_level[AW-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = r_val;
        out_load         = 1'b0;
        dwell            = r_rd_data[TBL_W-1:0];
        dc1              = r_dc + 16'd1;
        hit              = (dc1 >= dwell);
        dc_after         = hit ? 16'd0 : dc1;
        lvl_up           = {1'b0, r_level} + {{LVL_W{1'b0}}, hit};
        lvl_dn           = (hit && r_level != '0) ? r_level - 4'd1 : r_level;
        oc1              = r_oc + 16'd1;
        pc1              = r_pc + 32'd1;
        issue            = (r_cnt < r_target);
        per              = r_run ? r_rd_data[2*TBL_W-1:TBL_W] : 16'd0;
        n_out_data       = {7'd0, r_dir, r_run, r_bf, r_run, r_mode, r_level,
                            per[TBL_W-1:1], per};

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (s_axis_tuser == OP_TICK && r_run) begin
                        mem_rd_en = 1'b1;
                        n_state   = S_TICK;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_state = S_PRD;
                case (r_op)
                    OP_DIR: begin
                        n_dir = (r_val != '0);
                    end
                    OP_TARGET: begin
                        n_target = (r_val > VAL_W'(LEVELS - 1)) ? LVL_MAX : r_val[LVL_W-1:0];
                    end
                    OP_BUDGET: begin
                        div_req.start = 1'b1;
                        n_cnt         = '0;
                        n_sum         = '0;
                        n_acc_v       = 1'b0;
                        n_state       = S_DIV;
                    end
                    OP_ENABLE: begin
                        if (!r_run) begin
                            n_mode  = MODE_ACCEL;
                            n_level = '0;
                            n_run   = 1'b1;
                        end else if (r_level <= r_target) begin
                            n_mode = MODE_ACCEL;
                        end else begin
                            n_mode = MODE_DECEL;
                        end
                    end
                    OP_DISABLE: begin
                        if (r_run) begin
                            n_target = '0;
                            n_mode   = MODE_DECEL;
                        end
                    end
                    OP_STOP: begin
                        if (r_run && r_mode != MODE_STOP) begin
                            n_mode = MODE_STOP;
                        end
                    end
                    OP_WRITE: begin
                        mem_we = ({1'b0, r_idx} < LVL_CNT);
                    end
                    default: begin
                    end
                endcase
            end
            S_TICK: begin
                n_state = S_TBUD;
                case (r_mode)
                    MODE_ACCEL: begin
                        n_dc = dc_after;
                        if (lvl_up >= {1'b0, r_target}) begin
                            n_level = r_target;
                            n_mode  = MODE_STEADY;
                        end else begin
                            n_level = lvl_up[LVL_W-1:0];
                        end
                    end
                    MODE_DECEL: begin
                        n_dc = dc_after;
                        if (lvl_dn <= r_target) begin
                            n_level = r_target;
                            n_mode  = MODE_STEADY;
                            n_dc    = '0;
                        end else begin
                            n_level = lvl_dn;
                        end
                    end
                    MODE_STOP: begin
                        if (oc1 >= r_stop_offset) begin
                            n_oc    = '0;
                            n_dc    = '0;
                            n_level = '0;
                            n_mode  = MODE_STEADY;
                            n_pc    = '0;
                            n_bf    = 1'b0;
                            n_run   = 1'b0;
                        end else begin
                            n_oc    = r_oc + 16'd2;
                            n_level = lvl_dn;
                            n_dc    = (lvl_dn == '0) ? 16'd0 : dc_after;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_TBUD: begin
                n_state = S_PRD;
                if (r_bf) begin
                    n_pc = pc1;
                    if (pc1 >= r_decel && r_mode != MODE_DECEL) begin
                        n_target = '0;
                        n_mode   = MODE_DECEL;
                    end
                    if (pc1 >= r_budget) begin
                        n_oc    = '0;
                        n_dc    = '0;
                        n_level = '0;
                        n_mode  = MODE_STEADY;
                        n_pc    = '0;
                        n_bf    = 1'b0;
                        n_run   = 1'b0;
                    end
                end
            end
            S_DIV: begin
                if (!div_rsp.busy) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                mem_rd_en   = issue;
                mem_rd_addr = r_cnt[AW-1:0];
                if (r_acc_v) begin
                    n_sum = r_sum + SUM_W'(dwell);
                end
                n_acc_v = issue;
                if (issue) begin
                    n_cnt = r_cnt + 4'd1;
                end
                if (!issue && !r_acc_v) begin
                    n_state = S_BUD;
                end
            end
            S_BUD: begin
                n_state  = S_PRD;
                n_budget = r_val;
                n_bf     = 1'b1;
                if (VAL_W'({r_sum, 1'b0}) > r_val) begin
                    n_decel = div_rsp.quotient;
                    if (r_target != '0) begin
                        n_target = r_target - 4'd1;
                    end
                end else begin
                    n_decel = r_val - VAL_W'(r_sum);
                end
            end
            S_PRD: begin
                mem_rd_en = 1'b1;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // level table: {period, dwell}
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx[AW-1:0]] <= {r_wper, r_wdw};
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_level       <= '0;
            r_target      <= '0;
            r_mode        <= MODE_STEADY;
            r_run         <= 1'b0;
            r_bf          <= 1'b0;
            r_dir         <= 1'b0;
            r_dc          <= '0;
            r_oc          <= '0;
            r_pc          <= '0;
            r_budget      <= '0;
            r_decel       <= '0;
            r_cnt         <= '0;
            r_sum         <= '0;
            r_acc_v       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_stop_offset <= '0;
        end else begin
            r_state  <= n_state;
            r_level  <= n_level;
            r_target <= n_target;
            r_mode   <= n_mode;
            r_run    <= n_run;
            r_bf     <= n_bf;
            r_dir    <= n_dir;
            r_dc     <= n_dc;
            r_oc     <= n_oc;
            r_pc     <= n_pc;
            r_budget <= n_budget;
            r_decel  <= n_decel;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_acc_v  <= n_acc_v;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                r_stop_offset <= pwdata[TBL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op   <= s_axis_tuser;
            r_val  <= s_axis_tdata[31:0];
            r_idx  <= s_axis_tdata[35:32];
            r_wper <= s_axis_tdata[51:36];
            r_wdw  <= s_axis_tdata[67:52];
        end
        if (out_load) begin
            r_out_data <= n_out_data;
        end
    end

    `SRPC_ASSERT_ALWAYS(a_level_range, i_clk, i_rst_n,
        (r_level <= LVL_MAX) && (r_target <= LVL_MAX), "speed level out of range")
    `SRPC_ASSERT_IMP(a_idle_motor, i_clk, i_rst_n, !r_run,
        (r_level == '0) && (r_mode == MODE_STEADY), "stopped motor not at rest")
    `SRPC_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_acc,
        !s_axis_tready, "second item accepted while busy")
    `SRPC_ASSERT_IMP(a_sum_walk, i_clk, i_rst_n, r_state == S_SUM,
        r_cnt <= r_target, "dwell walk past target level")

endmodule

// ===== sv/srpc_div3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpc_div3
// Divide by three by reciprocal multiplication: operand registered on start,
// quotient registered in the cycle after.
// ----------------------------------------------------------------------------
module srpc_div3
    import srpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    // ceil(2^33 / 3); floor(x / 3) = (x * RECIP) >> 33 for any 32-bit x
    localparam logic [VAL_W-1:0] RECIP = 32'hAAAA_AAAB;

    logic [VAL_W-1:0]   r_dvd;
    logic [VAL_W-1:0]   r_quo;
    logic               r_busy;
    logic [2*VAL_W-1:0] prod;

    assign prod = (2*VAL_W)'(r_dvd) * (2*VAL_W)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_req.start;
        end
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
        end
        if (r_busy) begin
            r_quo <= VAL_W'(prod >> (VAL_W + 1));
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== sim/tb_stepper_ramp_profile_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_ramp_profile_controller
// Self-checking bench for the stepper ramp controller. It loads the level
// table and walks a short list of directed commands. It then runs four phases
// of random ramp profiles and noise, each with its own stop_offset written
// over APB. Every output transaction is checked field by field against an
// in-bench ramp model; both stream sides stall at random but in phase 1.
// ----------------------------------------------------------------------------
module tb_stepper_ramp_profile_controller
    import srpc_pkg::*;
();

    localparam int LEVELS      = LEVELS_DEF;
    localparam int N_DIRECTED  = 28;
    localparam int N_PHASES    = 4;
    localparam int PHASE_ITEMS = 425;
    localparam logic [ADDR_W-1:0] STOP_OFFSET_ADDR = ADDR_W'(4 * int'(REG_STOP_OFFSET));

    // Same bit order as m_axis_tdata[40:0].
    typedef struct packed {
        logic        turn_dir;
        logic        driver_enable;
        logic        budget_mode;
        logic        is_running;
        logic [1:0]  ramp_mode;
        logic [3:0]  speed_level;
        logic [14:0] step_compare;
        logic [15:0] step_period;
    } t_step_out;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [31:0]     value;
        logic [3:0]      index;
        logic [15:0]     period;
        logic [15:0]     dwell;
        logic            typed;
        t_step_out       want;
    } t_cmd_row;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // [31:0] value, [35:32] level_index, [51:36] level_period, [67:52] level_dwell
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    // [2:0] operation
    logic [OP_W-1:0]   s_axis_tuser  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // [15:0] step_period, [30:16] step_compare, [34:31] speed_level,
    // [36:35] ramp_mode, [37] is_running, [38] budget_mode,
    // [39] driver_enable, [40] turn_dir
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [31:0]       pwdata        = '0;
    logic [31:0]       prdata;
    logic              pready;

    stepper_ramp_profile_controller #(.LEVELS(LEVELS)) dut (.*);

    // ramp state
    logic [15:0] tbl_period [16] = '{default: '0};
    logic [15:0] tbl_dwell  [16] = '{default: '0};
    logic [3:0]  lvl           = '0;
    logic [3:0]  tgt           = '0;
    logic [1:0]  mode          = MODE_STEADY;
    logic        running       = 1'b0;
    logic        budget_on     = 1'b0;
    logic        ccw           = 1'b0;
    logic [15:0] dwell_cnt     = '0;
    logic [15:0] offset_cnt    = '0;
    logic [15:0] stop_offset_q = '0;
    logic [31:0] pulse_cnt     = '0;
    logic [31:0] budget_lim    = '0;
    logic [31:0] decel_at      = '0;

    t_step_out   pending_steps [$];
    logic        steady_flow = 1'b0;
    int unsigned n_items     = 0;
    int unsigned n_checked   = 0;
    int unsigned n_errs      = 0;
    int unsigned n_settings  = 0;
    int unsigned n_run_ticks = 0;
    int unsigned n_budgets   = 0;
    int unsigned n_halts     = 0;

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("** stepper_ramp_profile_controller: FAILED **");
        $finish;
    end

    function automatic void halt_motor();
        offset_cnt = '0;
        dwell_cnt  = '0;
        lvl        = '0;
        mode       = MODE_STEADY;
        pulse_cnt  = '0;
        budget_on  = 1'b0;
        running    = 1'b0;
        n_halts++;
    endfunction

    function automatic logic dwell_expired();
        dwell_cnt = dwell_cnt + 16'd1;
        if (dwell_cnt >= tbl_dwell[lvl]) begin
            dwell_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_step_out ramp_response(input logic [OP_W-1:0] op,
                                                input logic [31:0] value,
                                                input logic [3:0] index,
                                                input logic [15:0] period,
                                                input logic [15:0] dwell);
        logic        halt_now;
        logic [33:0] ramp_sum;
        int          i;
        t_step_out   r;
        case (op)
            OP_TICK: if (running) begin
                n_run_ticks++;
                case (mode)
                    MODE_ACCEL: begin
                        if (dwell_expired())
                            lvl = lvl + 4'd1;
                        if (lvl >= tgt) begin
                            lvl  = tgt;
                            mode = MODE_STEADY;
                        end
                    end
                    MODE_DECEL: begin
                        if (dwell_expired() && lvl != '0)
                            lvl = lvl - 4'd1;
                        if (lvl <= tgt) begin
                            lvl       = tgt;
                            mode      = MODE_STEADY;
                            dwell_cnt = '0;
                        end
                    end
                    MODE_STOP: begin
                        // offset advances by two per tick, halt tested after the first step
                        offset_cnt = offset_cnt + 16'd1;
                        halt_now   = offset_cnt >= stop_offset_q;
                        offset_cnt = offset_cnt + 16'd1;
                        if (halt_now) begin
                            halt_motor();
                        end else begin
                            if (dwell_expired() && lvl != '0)
                                lvl = lvl - 4'd1;
                            if (lvl == '0)
                                dwell_cnt = '0;
                        end
                    end
                    default: ;
                endcase
                if (budget_on) begin
                    pulse_cnt = pulse_cnt + 32'd1;
                    if (pulse_cnt >= decel_at && mode != MODE_DECEL) begin
                        tgt  = '0;
                        mode = MODE_DECEL;
                    end
                    if (pulse_cnt >= budget_lim)
                        halt_motor();
                end
            end
            OP_DIR: ccw = value != '0;
            OP_TARGET: tgt = (value > LEVELS - 1) ? 4'(LEVELS - 1) : value[3:0];
            OP_BUDGET: begin
                n_budgets++;
                budget_lim = value;
                budget_on  = 1'b1;
                ramp_sum   = '0;
                for (i = 0; i < int'(tgt); i++)
                    ramp_sum = ramp_sum + 34'(tbl_dwell[i]);
                if ((ramp_sum << 1) > 34'(value)) begin
                    decel_at = value / 32'd3;
                    if (tgt != '0)
                        tgt = tgt - 4'd1;
                end else begin
                    decel_at = value - ramp_sum[31:0];
                end
            end
            OP_ENABLE: if (!running) begin
                mode    = MODE_ACCEL;
                lvl     = '0;
                running = 1'b1;
            end else if (lvl <= tgt) begin
                mode = MODE_ACCEL;
            end else begin
                mode = MODE_DECEL;
            end
            OP_DISABLE: if (running) begin
                tgt  = '0;
                mode = MODE_DECEL;
            end
            OP_STOP: if (running && mode != MODE_STOP)
                mode = MODE_STOP;
            default: if (index < LEVELS) begin
                tbl_period[index] = period;
                tbl_dwell[index]  = dwell;
            end
        endcase
        r.step_period   = running ? tbl_period[lvl] : '0;
        r.step_compare  = r.step_period[15:1];
        r.speed_level   = lvl;
        r.ramp_mode     = mode;
        r.is_running    = running;
        r.budget_mode   = budget_on;
        r.driver_enable = running;
        r.turn_dir      = ccw;
        return r;
    endfunction

    function automatic t_step_out fixed_out(input logic [15:0] period, input logic [1:0] m,
                                            input logic run, input logic bud, input logic dir);
        t_step_out r;
        r.step_period   = period;
        r.step_compare  = period[15:1];
        r.speed_level   = '0;
        r.ramp_mode     = m;
        r.is_running    = run;
        r.budget_mode   = bud;
        r.driver_enable = run;
        r.turn_dir      = dir;
        return r;
    endfunction

    function automatic logic [15:0] pick_dwell(input logic tame);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70 || (tame && r < 90))
            return 16'($urandom_range(0, 3));
        if (r < 95 || tame)
            return 16'($urandom_range(4, 24));
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_target();
        if ($urandom_range(99) < 85)
            return 32'($urandom_range(0, 15));
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_budget();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 32'($urandom_range(1, 200));
        if (r < 75)
            return 32'($urandom_range(0, 20));
        if (r < 90)
            return 32'($urandom_range(200, 5000));
        return $urandom;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            n_errs++;
            if (n_errs <= 20)
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [31:0] value,
                             input logic [3:0] index, input logic [15:0] period,
                             input logic [15:0] dwell);
        while (!steady_flow && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'h0, dwell, period, index, value};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pending_steps.push_back(ramp_response(op, value, index, period, dwell));
        n_items++;
    endtask

    // table fields carry noise on every command but the table write
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [31:0] value);
        send_item(op, value, 4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom));
    endtask

    task automatic write_stop_offset(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STOP_OFFSET_ADDR;
        pwdata  <= {16'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        stop_offset_q = v;
        n_settings++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        check_field("prdata", {16'h0000, v}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= steady_flow || ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin : result_check
        t_step_out got;
        t_step_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_step_out'(m_axis_tdata[40:0]);
            if (pending_steps.size() == 0) begin
                n_errs++;
                if (n_errs <= 20)
                    $display("%0t: unexpected transaction: expected none, actual 0x%0h",
                             $time, m_axis_tdata);
            end else begin
                want = pending_steps.pop_front();
                n_checked++;
                check_field("step_period", 32'(want.step_period), 32'(got.step_period));
                check_field("step_compare", 32'(want.step_compare), 32'(got.step_compare));
                check_field("speed_level", 32'(want.speed_level), 32'(got.speed_level));
                check_field("ramp_mode", 32'(want.ramp_mode), 32'(got.ramp_mode));
                check_field("is_running", 32'(want.is_running), 32'(got.is_running));
                check_field("budget_mode", 32'(want.budget_mode), 32'(got.budget_mode));
                check_field("driver_enable", 32'(want.driver_enable), 32'(got.driver_enable));
                check_field("turn_dir", 32'(want.turn_dir), 32'(got.turn_dir));
                check_field("tdata pad", 32'h0, 32'(m_axis_tdata[OUT_W-1:41]));
            end
        end
    end

    initial begin : stimulus
        t_cmd_row        rows [N_DIRECTED];
        logic [15:0]     offsets [N_PHASES];
        logic [OP_W-1:0] op;
        int unsigned     phase_end;
        int unsigned     r;

        rows = '{
            '{OP_TICK,    32'h0000_0000, 4'd0,  16'h0000, 16'h0000, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b0)},
            '{OP_DIR,     32'hFFFF_FFFF, 4'd0,  16'h0000, 16'h0000, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_DISABLE, 32'h0000_0000, 4'd0,  16'h0000, 16'h0000, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_STOP,    32'h0000_0000, 4'd0,  16'h0000, 16'h0000, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd0,  16'hFFFF, 16'h0000, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd1,  16'h1234, 16'h0001, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd2,  16'h2468, 16'h0002, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd3,  16'h0F0F, 16'h0001, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd4,  16'hF0F0, 16'h0002, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd5,  16'h5555, 16'h0001, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd6,  16'hAAAA, 16'h0003, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd7,  16'h0800, 16'h0001, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd8,  16'h0400, 16'h0002, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd9,  16'h0200, 16'h0001, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd10, 16'h0100, 16'h0002, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd11, 16'h0080, 16'h0001, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd12, 16'h0040, 16'h0001, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_WRITE,   32'h0000_0000, 4'd13, 16'h0000, 16'hFFFF, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            '{OP_TARGET,  32'hFFFF_FFFF, 4'd0,  16'h0000, 16'h0000, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)},
            // ramp sum too long for this budget: target drops, decel point is budget / 3
            '{OP_BUDGET,  32'h0000_0002, 4'd0,  16'h0000, 16'h0000, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b1, 1'b1)},
            '{OP_ENABLE,  32'h0000_0000, 4'd0,  16'h0000, 16'h0000, 1'b1,
              fixed_out(16'hFFFF, MODE_ACCEL, 1'b1, 1'b1, 1'b1)},
            '{OP_TICK,    32'h0000_0000, 4'd0,  16'h0000, 16'h0000, 1'b0, '0},
            '{OP_TICK,    32'h0000_0000, 4'd0,  16'h0000, 16'h0000, 1'b0, '0},
            '{OP_ENABLE,  32'h0000_0000, 4'd0,  16'h0000, 16'h0000, 1'b1,
              fixed_out(16'hFFFF, MODE_ACCEL, 1'b1, 1'b0, 1'b1)},
            '{OP_STOP,    32'h0000_0000, 4'd0,  16'h0000, 16'h0000, 1'b0, '0},
            '{OP_STOP,    32'h0000_0000, 4'd0,  16'h0000, 16'h0000, 1'b0, '0},
            '{OP_TICK,    32'h0000_0000, 4'd0,  16'h0000, 16'h0000, 1'b1,
              fixed_out(16'h0000, MODE_STEADY, 1'b0, 1'b0, 1'b1)}
        };
        offsets = '{16'hFFFF, 16'($urandom_range(1, 24)), 16'($urandom), 16'h0002};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_stop_offset(16'h0000);
        foreach (rows[k]) begin
            send_item(rows[k].op, rows[k].value, rows[k].index, rows[k].period, rows[k].dwell);
            if (rows[k].typed)
                pending_steps[$] = rows[k].want;
        end
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            write_stop_offset(offsets[p]);
            steady_flow = (p == 1);
            phase_end   = n_items + PHASE_ITEMS;
            while (n_items < phase_end) begin
                if ($urandom_range(99) < 75) begin
                    // ramp profile: touch up table, maybe turn, aim, maybe budget, start, pulse, maybe wind down
                    repeat ($urandom_range(0, 2))
                        send_item(OP_WRITE, $urandom, 4'($urandom_range(0, LEVELS - 1)),
                                  16'($urandom), pick_dwell(1'b1));
                    if ($urandom_range(99) < 40)
                        send_cmd(OP_DIR, $urandom_range(0, 1) ? $urandom : 32'h0);
                    send_cmd(OP_TARGET, pick_target());
                    if ($urandom_range(99) < 50)
                        send_cmd(OP_BUDGET, pick_budget());
                    send_cmd(OP_ENABLE, $urandom);
                    repeat ($urandom_range(4, 40)) begin
                        r = $urandom_range(99);
                        if (r < 6)
                            send_cmd(OP_TARGET, pick_target());
                        else if (r < 10)
                            send_cmd(OP_ENABLE, $urandom);
                        else
                            send_cmd(OP_TICK, $urandom);
                    end
                    r = $urandom_range(99);
                    if (r < 70) begin
                        send_cmd((r < 40) ? OP_STOP : OP_DISABLE, $urandom);
                        repeat ($urandom_range(0, 30))
                            send_cmd(OP_TICK, $urandom);
                    end
                end else begin
                    op = OP_W'($urandom_range(0, 7));
                    case (op)
                        OP_WRITE: send_item(OP_WRITE, $urandom, 4'($urandom_range(0, 15)),
                                            16'($urandom), pick_dwell(1'b0));
                        OP_TARGET: send_cmd(OP_TARGET, pick_target());
                        OP_BUDGET: send_cmd(OP_BUDGET, pick_budget());
                        OP_DIR: send_cmd(OP_DIR, $urandom_range(0, 1) ? $urandom : 32'h0);
                        default: send_cmd(op, $urandom);
                    endcase
                end
            end
            drain();
        end
        steady_flow = 1'b0;

        $display("Covered %0d transactions, %0d results checked, %0d stop_offset settings.",
                 n_items, n_checked, n_settings);
        $display("Running ticks: %0d, pulse budget loads: %0d, motor halts: %0d.",
                 n_run_ticks, n_budgets, n_halts);
        if (n_errs == 0) begin
            $display("** stepper_ramp_profile_controller: PASSED **");
        end else begin
            $display("** stepper_ramp_profile_controller: FAILED **");
        end
        $finish;
    end

endmodule
